FILE: rtl/ssc_pkg.sv
// ----------------------------------------------------------------------------
// Sphere contact package
// Shared widths and payload types of the sphere-to-sphere contact pipeline.
// ----------------------------------------------------------------------------
package ssc_pkg;

    localparam int CoordW = 32;  // signed Q15.16 centre coordinate
    localparam int RadW   = 31;  // unsigned Q15.16 radius
    localparam int MagW   = 32;  // |delta| on a candidate contact, Q16.16
    localparam int SqW    = 64;  // squared length, 2^-32 units
    localparam int RootW  = 32;  // floor square root, Q16.16
    localparam int RemW   = 33;  // square root partial remainder
    localparam int QuotW  = 17;  // normal magnitude, at most 1.0 in Q1.16
    localparam int FracW  = 16;  // fraction bits of Q16.16
    localparam int NormW  = 18;  // signed Q1.16 normal component
    localparam int DepthW = 32;  // unsigned Q16.16 depth

    localparam logic signed [NormW-1:0] NormOne = NormW'(1 << FracW);

    typedef struct packed {
        logic signed [CoordW-1:0] first_x;
        logic signed [CoordW-1:0] first_y;
        logic signed [CoordW-1:0] first_z;
        logic        [RadW-1:0]   first_radius;
        logic signed [CoordW-1:0] second_x;
        logic signed [CoordW-1:0] second_y;
        logic signed [CoordW-1:0] second_z;
        logic        [RadW-1:0]   second_radius;
    } t_in_item;

    // Per-item geometry that travels down the root and divide stages.
    typedef struct packed {
        logic                      hit;
        logic [2:0]                neg;
        logic [2:0][MagW-1:0]      mag;
        logic [DepthW-1:0]         rs;
    } t_geo;

endpackage

FILE: rtl/ssc_intf.sv
// ----------------------------------------------------------------------------
// Sphere contact channels
// Valid/ready channels for sphere pairs in and contact results out.
// ----------------------------------------------------------------------------
interface ssc_in_if;
    import ssc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [CoordW-1:0] first_x;
    logic signed [CoordW-1:0] first_y;
    logic signed [CoordW-1:0] first_z;
    logic        [RadW-1:0]   first_radius;
    logic signed [CoordW-1:0] second_x;
    logic signed [CoordW-1:0] second_y;
    logic signed [CoordW-1:0] second_z;
    logic        [RadW-1:0]   second_radius;

    modport source (output valid, first_x, first_y, first_z, first_radius,
                     second_x, second_y, second_z, second_radius, input ready);
    modport sink   (input valid, first_x, first_y, first_z, first_radius,
                     second_x, second_y, second_z, second_radius, output ready);
endinterface

interface ssc_out_if;
    import ssc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    touching;
    logic signed [NormW-1:0] normal_x;
    logic signed [NormW-1:0] normal_y;
    logic signed [NormW-1:0] normal_z;
    logic        [DepthW-1:0] depth;

    modport source (output valid, touching, normal_x, normal_y, normal_z, depth,
                     input ready);
    modport sink   (input valid, touching, normal_x, normal_y, normal_z, depth,
                     output ready);
endinterface

FILE: rtl/ssc_front.sv
// ----------------------------------------------------------------------------
// Sphere contact front end
// Centre delta, magnitudes, squares and the strict contact compare, 4 stages.
// ----------------------------------------------------------------------------
module ssc_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  ssc_pkg::t_in_item        i_item,
    output logic                     o_valid,
    output ssc_pkg::t_geo            o_geo,
    output logic [ssc_pkg::SqW-1:0]  o_sum
);
    import ssc_pkg::*;

    logic [3:0] r_vld;

    // Stage 1: deltas and radius sum.
    logic signed [CoordW:0] r_d [3];
    logic [DepthW-1:0]      r_rs1;
    // Stage 2: magnitudes and per-axis reject.
    logic [2:0][MagW-1:0]   r_mag2;
    logic [2:0]             r_neg2;
    logic                   r_far2;
    logic [DepthW-1:0]      r_rs2;
    // Stage 3: squares.
    logic [SqW-1:0]         r_sq [3];
    logic [SqW-1:0]         r_rsq;
    logic [2:0][MagW-1:0]   r_mag3;
    logic [2:0]             r_neg3;
    logic                   r_far3;
    logic [DepthW-1:0]      r_rs3;
    // Stage 4: sum and compare.
    t_geo                   r_geo;
    logic [SqW-1:0]         r_sum;

    logic signed [CoordW:0] n_d [3];
    logic [CoordW:0]        n_abs [3];
    logic [2:0]             n_far;
    logic [SqW+1:0]         n_sum;

    always_comb begin
        n_d[0] = $signed({i_item.second_x[CoordW-1], i_item.second_x})
               - $signed({i_item.first_x[CoordW-1], i_item.first_x});
        n_d[1] = $signed({i_item.second_y[CoordW-1], i_item.second_y})
               - $signed({i_item.first_y[CoordW-1], i_item.first_y});
        n_d[2] = $signed({i_item.second_z[CoordW-1], i_item.second_z})
               - $signed({i_item.first_z[CoordW-1], i_item.first_z});
        for (int i = 0; i < 3; i++) begin
            n_abs[i] = r_d[i][CoordW] ? (CoordW+1)'(-r_d[i]) : (CoordW+1)'(r_d[i]);
            n_far[i] = n_abs[i] >= {1'b0, r_rs1};
        end
        // An overflow past 64 bits still lands above the 64-bit radius square.
        n_sum = (SqW+2)'(r_sq[0]) + (SqW+2)'(r_sq[1]) + (SqW+2)'(r_sq[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_d[i]    <= n_d[i];
                r_mag2[i] <= n_abs[i][MagW-1:0];
                r_neg2[i] <= r_d[i][CoordW];
                r_sq[i]   <= r_mag2[i] * r_mag2[i];
            end
            r_rs1  <= {1'b0, i_item.first_radius} + {1'b0, i_item.second_radius};
            r_far2 <= |n_far;
            r_rs2  <= r_rs1;

            r_rsq  <= r_rs2 * r_rs2;
            r_mag3 <= r_mag2;
            r_neg3 <= r_neg2;
            r_far3 <= r_far2;
            r_rs3  <= r_rs2;

            r_geo.hit <= !r_far3 && (n_sum < (SqW+2)'(r_rsq));
            r_geo.neg <= r_neg3;
            r_geo.mag <= r_mag3;
            r_geo.rs  <= r_rs3;
            r_sum     <= n_sum[SqW-1:0];
        end
    end

    assign o_valid = r_vld[3];
    assign o_geo   = r_geo;
    assign o_sum   = r_sum;

endmodule

FILE: rtl/ssc_sqrt.sv
// ----------------------------------------------------------------------------
// Sphere contact square root
// Floor square root of the squared distance, one root bit per stage.
// ----------------------------------------------------------------------------
module ssc_sqrt (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  ssc_pkg::t_geo             i_geo,
    input  logic [ssc_pkg::SqW-1:0]   i_sum,
    output logic                      o_valid,
    output ssc_pkg::t_geo             o_geo,
    output logic [ssc_pkg::RootW-1:0] o_root
);
    import ssc_pkg::*;

    logic [RootW-1:0] r_vld;
    t_geo             r_geo  [RootW];
    logic [SqW-1:0]   r_rad  [RootW];
    logic [RemW-1:0]  r_rem  [RootW];
    logic [RootW-1:0] r_root [RootW];

    for (genvar k = 0; k < RootW; k++) begin : g_stage
        logic             w_vld;
        t_geo             w_geo;
        logic [SqW-1:0]   w_rad;
        logic [RemW-1:0]  w_rem;
        logic [RootW-1:0] w_root;
        logic [RemW+1:0]  w_try;
        logic [RemW+1:0]  w_sub;
        logic             w_ge;

        if (k == 0) begin : g_head
            assign w_vld  = i_valid;
            assign w_geo  = i_geo;
            assign w_rad  = i_sum;
            assign w_rem  = '0;
            assign w_root = '0;
        end else begin : g_body
            assign w_vld  = r_vld[k-1];
            assign w_geo  = r_geo[k-1];
            assign w_rad  = r_rad[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_root = r_root[k-1];
        end

        // Bring down the next two bits and try the digit one.
        assign w_try = {w_rem, w_rad[SqW-1:SqW-2]};
        assign w_sub = (RemW+2)'({w_root, 2'b01});
        assign w_ge  = w_try >= w_sub;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_geo[k]  <= w_geo;
                r_rad[k]  <= {w_rad[SqW-3:0], 2'b00};
                r_rem[k]  <= w_ge ? RemW'(w_try - w_sub) : RemW'(w_try);
                r_root[k] <= {w_root[RootW-2:0], w_ge};
            end
        end
    end

    assign o_valid = r_vld[RootW-1];
    assign o_geo   = r_geo[RootW-1];
    assign o_root  = r_root[RootW-1];

endmodule

FILE: rtl/ssc_div.sv
// ----------------------------------------------------------------------------
// Sphere contact normal divider
// Three restoring dividers form |d| * 2^16 / dist, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ssc_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  ssc_pkg::t_geo             i_geo,
    input  logic [ssc_pkg::RootW-1:0] i_dist,
    output logic                      o_valid,
    output ssc_pkg::t_geo             o_geo,
    output logic [ssc_pkg::RootW-1:0] o_dist,
    output logic [2:0][ssc_pkg::QuotW-1:0] o_quot
);
    import ssc_pkg::*;

    logic [QuotW-1:0]             r_vld;
    t_geo                         r_geo  [QuotW];
    logic [RootW-1:0]             r_dist [QuotW];
    logic [2:0][RootW-1:0]        r_rem  [QuotW];
    logic [2:0][QuotW-1:0]        r_sh   [QuotW];
    logic [2:0][QuotW-1:0]        r_q    [QuotW];

    for (genvar k = 0; k < QuotW; k++) begin : g_stage
        logic                  w_vld;
        t_geo                  w_geo;
        logic [RootW-1:0]      w_dist;
        logic [2:0][RootW-1:0] w_rem;
        logic [2:0][QuotW-1:0] w_sh;
        logic [2:0][QuotW-1:0] w_q;
        logic [2:0][RootW-1:0] n_rem;
        logic [2:0][QuotW-1:0] n_q;

        if (k == 0) begin : g_head
            // The high quotient bits are zero since |d| <= dist, so the
            // division starts with |d| >> 1 already brought down.
            assign w_vld  = i_valid;
            assign w_geo  = i_geo;
            assign w_dist = i_dist;
            for (genvar a = 0; a < 3; a++) begin : g_axis
                assign w_rem[a] = {1'b0, i_geo.mag[a][MagW-1:1]};
                assign w_sh[a]  = {i_geo.mag[a][0], FracW'(0)};
                assign w_q[a]   = '0;
            end
        end else begin : g_body
            assign w_vld  = r_vld[k-1];
            assign w_geo  = r_geo[k-1];
            assign w_dist = r_dist[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_sh   = r_sh[k-1];
            assign w_q    = r_q[k-1];
        end

        always_comb begin
            logic [RootW:0] t;
            for (int a = 0; a < 3; a++) begin
                t = {w_rem[a], w_sh[a][QuotW-1]};
                if (t >= {1'b0, w_dist}) begin
                    n_rem[a] = RootW'(t - {1'b0, w_dist});
                    n_q[a]   = {w_q[a][QuotW-2:0], 1'b1};
                end else begin
                    n_rem[a] = RootW'(t);
                    n_q[a]   = {w_q[a][QuotW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_geo[k]  <= w_geo;
                r_dist[k] <= w_dist;
                r_rem[k]  <= n_rem;
                for (int a = 0; a < 3; a++) begin
                    r_sh[k][a] <= {w_sh[a][QuotW-2:0], 1'b0};
                end
                r_q[k]    <= n_q;
            end
        end
    end

    assign o_valid = r_vld[QuotW-1];
    assign o_geo   = r_geo[QuotW-1];
    assign o_dist  = r_dist[QuotW-1];
    assign o_quot  = r_q[QuotW-1];

endmodule

FILE: rtl/sphere_sphere_contact_top.sv
// Pipeline from input transfer to result: 4 front-end stages,
// 32 square root stages (one root bit each), 17 divide stages and an output register.
// Throughput: one sphere pair per cycle; a stalled output holds the whole pipe.
// Reset: synchronous active-low i_rst_n clears every stage valid bit; data
// registers are not reset.
// ----------------------------------------------------------------------------
// Sphere-to-sphere contact top level
// Contact flag, unit normal and depth for a stream of sphere pairs.
// ----------------------------------------------------------------------------
module sphere_sphere_contact_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ssc_in_if.sink    i_item,
    ssc_out_if.source o_res
);
    import ssc_pkg::*;

    logic                  w_en;
    t_in_item              w_item;
    logic                  w_f_vld;
    t_geo                  w_f_geo;
    logic [SqW-1:0]        w_f_sum;
    logic                  w_s_vld;
    t_geo                  w_s_geo;
    logic [RootW-1:0]      w_s_root;
    logic                  w_d_vld;
    t_geo                  w_d_geo;
    logic [RootW-1:0]      w_d_dist;
    logic [2:0][QuotW-1:0] w_d_quot;

    logic                    r_vld;
    logic                    r_touch;
    logic signed [NormW-1:0] r_nrm [3];
    logic [DepthW-1:0]       r_depth;
    logic signed [NormW-1:0] n_nrm [3];

    assign w_en         = !r_vld || o_res.ready;
    assign i_item.ready = w_en;

    assign w_item.first_x       = i_item.first_x;
    assign w_item.first_y       = i_item.first_y;
    assign w_item.first_z       = i_item.first_z;
    assign w_item.first_radius  = i_item.first_radius;
    assign w_item.second_x      = i_item.second_x;
    assign w_item.second_y      = i_item.second_y;
    assign w_item.second_z      = i_item.second_z;
    assign w_item.second_radius = i_item.second_radius;

    ssc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_item.valid),
        .i_item  (w_item),
        .o_valid (w_f_vld),
        .o_geo   (w_f_geo),
        .o_sum   (w_f_sum)
    );

    ssc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_vld),
        .i_geo   (w_f_geo),
        .i_sum   (w_f_sum),
        .o_valid (w_s_vld),
        .o_geo   (w_s_geo),
        .o_root  (w_s_root)
    );

    ssc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_s_vld),
        .i_geo   (w_s_geo),
        .i_dist  (w_s_root),
        .o_valid (w_d_vld),
        .o_geo   (w_d_geo),
        .o_dist  (w_d_dist),
        .o_quot  (w_d_quot)
    );

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_nrm[a] = w_d_geo.neg[a] ? -$signed(NormW'(w_d_quot[a]))
                                      : $signed(NormW'(w_d_quot[a]));
        end
        // Coincident centres report straight up.
        if (w_d_dist == '0) begin
            n_nrm[0] = '0;
            n_nrm[1] = NormOne;
            n_nrm[2] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_en) begin
            r_vld <= w_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_touch <= w_d_geo.hit;
            for (int a = 0; a < 3; a++) begin
                r_nrm[a] <= w_d_geo.hit ? n_nrm[a] : '0;
            end
            r_depth <= w_d_geo.hit ? w_d_geo.rs - w_d_dist : '0;
        end
    end

    assign o_res.valid    = r_vld;
    assign o_res.touching = r_touch;
    assign o_res.normal_x = r_nrm[0];
    assign o_res.normal_y = r_nrm[1];
    assign o_res.normal_z = r_nrm[2];
    assign o_res.depth    = r_depth;

    a_miss_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.touching |-> o_res.depth == '0)
        else $error("depth nonzero without contact");
    a_hit_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.touching |-> o_res.depth != '0)
        else $error("zero depth on contact");
    a_nx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> o_res.normal_x <= NormOne && o_res.normal_x >= -NormOne)
        else $error("normal x out of range");
    a_ny_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> o_res.normal_y <= NormOne && o_res.normal_y >= -NormOne)
        else $error("normal y out of range");

endmodule
